// ===== hdl/ppu_pkg.sv =====
// ----------------------------------------------------------------------------
// ppu_pkg
// Shared types and codes of the particle pool: transaction payloads, the
// per-slot memory word and the sequencer states.
// ----------------------------------------------------------------------------
package ppu_pkg;

	localparam logic [1:0] KIND_SPAWN  = 2'd0;
	localparam logic [1:0] KIND_TICK   = 2'd1;
	localparam logic [1:0] KIND_DRAW   = 2'd2;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	localparam int QUO_W = 16;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic [31:0]        edge_size;
		logic [31:0]        life_time;
		logic [31:0]        birth_colour;
		logic [31:0]        death_colour;
		logic [15:0]        texture_id;
		logic [15:0]        shader_id;
		logic [31:0]        time_step;
	} req_t;

	typedef struct packed {
		logic [5:0]         slot;
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic [31:0]        out_size;
		logic [31:0]        out_colour;
		logic [15:0]        out_texture;
		logic [15:0]        out_shader;
		logic               last;
	} rsp_t;

	// one memory word per slot
	typedef struct packed {
		logic [31:0] age;
		logic [31:0] lifespan;
		logic [31:0] place_x;
		logic [31:0] place_y;
		logic [31:0] speed_x;
		logic [31:0] speed_y;
		logic [31:0] side;
		logic [31:0] start_colour;
		logic [31:0] end_colour;
		logic [31:0] now_colour;
		logic [31:0] handles;
	} entry_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TK_RD,
		ST_TK_LOAD,
		ST_TK_MX,
		ST_TK_MY,
		ST_TK_DIV,
		ST_TK_WB,
		ST_DR_RD,
		ST_DR_OUT
	} state_t;

endpackage

// ===== hdl/ppu_div.sv =====
// ----------------------------------------------------------------------------
// ppu_div
// Serial restoring divider: (num << 16) / den, one quotient bit per cycle.
// Requires num < den, so the quotient fits in 16 bits.
// ----------------------------------------------------------------------------
module ppu_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [31:0]                 num,
	input  logic [31:0]                 den,
	output logic                        done,
	output logic [ppu_pkg::QUO_W-1:0]   quo
);

	logic        busy_q;
	logic        done_q;
	logic [3:0]  cnt_q;
	logic [31:0] rem_q;
	logic [31:0] den_q;
	logic [ppu_pkg::QUO_W-1:0] quo_q;
	logic [32:0] rem_sh;
	logic        fits;

	assign rem_sh = {rem_q, 1'b0};
	assign fits   = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'(ppu_pkg::QUO_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? 32'(rem_sh - {1'b0, den_q}) : rem_sh[31:0];
			quo_q <= {quo_q[ppu_pkg::QUO_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ===== hdl/particle_pool_update.sv =====
// ----------------------------------------------------------------------------
// particle_pool_update
// Particle pool of SLOTS slots held in one synchronous memory: spawn, age,
// move and recolour, and draw of all live particles.
// ----------------------------------------------------------------------------
// usage
//   req channel (req_valid / req_stall / req): one transaction per command,
//   kind selects spawn, tick or draw; kind 3 is taken and ignored
//   rsp channel (rsp_valid / rsp_stall / rsp): one transaction per live slot
//   on a draw, in slot order, last set on the final one; none for empty pools
//   spawn: taken from idle and written to memory at the accept edge
//   tick: free slots are skipped; a live slot that survives goes through memory
//   read, two 32x32 products, the serial divider and write back; a live slot
//   that expires is cleared after its memory read
//   draw: free slots are skipped; each live slot is read, then output, waiting while rsp is stalled
//   req_stall stays high until the command is finished
//   the result sits in an output register; a stall on rsp holds it and the
//   draw scan waits, the next command may start while it waits
//   reset clears the live flags and the spawn pointer; the memory itself
//   is not cleared, a slot is fully written at the edge that marks it live
// ----------------------------------------------------------------------------
module particle_pool_update #(
	parameter int SLOTS = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  ppu_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output ppu_pkg::rsp_t  rsp
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	// slot memory: a registered read every cycle, plus a write when mem_we is set
	ppu_pkg::entry_t mem [SLOTS];
	ppu_pkg::entry_t rd_q;
	logic            mem_we;
	logic [IW-1:0]   mem_waddr;
	ppu_pkg::entry_t mem_wdata;
	logic [IW-1:0]   mem_raddr;

	ppu_pkg::state_t state_q, state_d;
	logic [SLOTS-1:0] live_q;
	logic [IW-1:0]    next_q;
	logic [IW-1:0]    idx_q;
	logic [31:0]      step_q;
	ppu_pkg::entry_t  ent_q;
	logic [63:0]      prod_q;
	logic [15:0]      interp_q;
	logic             rsp_valid_q;
	ppu_pkg::rsp_t    rsp_q;

	logic             accept;
	logic             idx_end;
	logic [32:0]      age_sum;
	logic [31:0]      age_new;
	logic             expire;
	logic [31:0]      mag_x, mag_y;
	logic [31:0]      delta;
	logic [31:0]      blended;
	logic [SLOTS-1:0] above;
	logic             last_live;
	logic             out_free;
	logic             div_start;
	logic             div_done;
	logic [15:0]      div_quo;
	ppu_pkg::entry_t  spawn_ent;
	ppu_pkg::entry_t  load_ent;
	logic [31:0]      half;

	assign accept   = req_valid && !req_stall;
	assign idx_end  = idx_q == IW'(SLOTS - 1);
	assign out_free = !rsp_valid_q || !rsp_stall;

	// saturating age
	assign age_sum = {1'b0, rd_q.age} + {1'b0, step_q};
	assign age_new = age_sum[32] ? 32'hFFFF_FFFF : age_sum[31:0];
	assign expire  = age_new >= rd_q.lifespan;

	// loaded word with the new age
	always_comb begin
		load_ent     = rd_q;
		load_ent.age = age_new;
	end

	// velocity magnitudes; the most negative value maps to itself
	assign mag_x = rd_q.speed_x[31] ? 32'(-rd_q.speed_x) : rd_q.speed_x;
	assign mag_y = ent_q.speed_y[31] ? 32'(-ent_q.speed_y) : ent_q.speed_y;

	// signed distance from the registered product, truncated toward zero
	always_comb begin
		delta = prod_q[47:16];
		if ((state_q == ppu_pkg::ST_TK_MX && ent_q.speed_x[31]) ||
			(state_q == ppu_pkg::ST_TK_MY && ent_q.speed_y[31])) begin
			delta = 32'(-prod_q[47:16]);
		end
	end

	// per-channel colour blend
	always_comb begin
		logic [7:0]  cb, cd, diff;
		logic [23:0] p;
		blended = '0;
		for (int c = 0; c < 4; c++) begin
			cb   = ent_q.start_colour[c*8 +: 8];
			cd   = ent_q.end_colour[c*8 +: 8];
			diff = (cd >= cb) ? cd - cb : cb - cd;
			p    = {16'd0, diff} * {8'd0, interp_q};
			blended[c*8 +: 8] = (cd >= cb) ? cb + p[23:16] : cb - p[23:16];
		end
	end

	// no live slot above the current one
	assign above     = live_q >> idx_q;
	assign last_live = ~|above[SLOTS-1:1];

	// spawn word
	assign half = {1'b0, req.edge_size[31:1]};
	always_comb begin
		spawn_ent.age          = '0;
		spawn_ent.lifespan     = req.life_time;
		spawn_ent.place_x      = req.pos_x - half;
		spawn_ent.place_y      = req.pos_y - half;
		spawn_ent.speed_x      = req.vel_x;
		spawn_ent.speed_y      = req.vel_y;
		spawn_ent.side         = req.edge_size;
		spawn_ent.start_colour = req.birth_colour;
		spawn_ent.end_colour   = req.death_colour;
		spawn_ent.now_colour   = req.birth_colour;
		spawn_ent.handles      = {req.shader_id, req.texture_id};
	end

	// next state and memory control
	always_comb begin
		state_d   = state_q;
		req_stall = state_q != ppu_pkg::ST_IDLE;
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = ent_q;
		mem_raddr = idx_q;
		div_start = 1'b0;
		case (state_q)
			ppu_pkg::ST_IDLE: begin
				if (req_valid) begin
					case (req.kind)
						ppu_pkg::KIND_SPAWN: begin
							mem_we    = 1'b1;
							mem_waddr = next_q;
							mem_wdata = spawn_ent;
						end
						ppu_pkg::KIND_TICK: state_d = ppu_pkg::ST_TK_RD;
						ppu_pkg::KIND_DRAW: state_d = ppu_pkg::ST_DR_RD;
						default: state_d = ppu_pkg::ST_IDLE;
					endcase
				end
			end
			ppu_pkg::ST_TK_RD: begin
				if (live_q[idx_q]) state_d = ppu_pkg::ST_TK_LOAD;
				else if (idx_end) state_d = ppu_pkg::ST_IDLE;
			end
			ppu_pkg::ST_TK_LOAD: begin
				if (!expire) state_d = ppu_pkg::ST_TK_MX;
				else if (idx_end) state_d = ppu_pkg::ST_IDLE;
				else state_d = ppu_pkg::ST_TK_RD;
			end
			ppu_pkg::ST_TK_MX: state_d = ppu_pkg::ST_TK_MY;
			ppu_pkg::ST_TK_MY: begin
				div_start = 1'b1;
				state_d   = ppu_pkg::ST_TK_DIV;
			end
			ppu_pkg::ST_TK_DIV: begin
				if (div_done) state_d = ppu_pkg::ST_TK_WB;
			end
			ppu_pkg::ST_TK_WB: begin
				mem_we               = 1'b1;
				mem_wdata.now_colour = blended;
				state_d = idx_end ? ppu_pkg::ST_IDLE : ppu_pkg::ST_TK_RD;
			end
			ppu_pkg::ST_DR_RD: begin
				if (live_q[idx_q]) state_d = ppu_pkg::ST_DR_OUT;
				else if (idx_end) state_d = ppu_pkg::ST_IDLE;
			end
			ppu_pkg::ST_DR_OUT: begin
				if (out_free) state_d = idx_end ? ppu_pkg::ST_IDLE : ppu_pkg::ST_DR_RD;
			end
			default: state_d = ppu_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ppu_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	// memory
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		rd_q <= mem[mem_raddr];
	end

	// control state: live flags, spawn pointer, scan index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q      <= '0;
			next_q      <= '0;
			idx_q       <= '0;
		end else begin
			case (state_q)
				ppu_pkg::ST_IDLE: begin
					idx_q <= '0;
					if (accept && req.kind == ppu_pkg::KIND_SPAWN) begin
						live_q[next_q] <= 1'b1;
						next_q <= (next_q == IW'(SLOTS - 1)) ? '0 : next_q + 1'b1;
					end
				end
				ppu_pkg::ST_TK_RD,
				ppu_pkg::ST_DR_RD: begin
					if (!live_q[idx_q]) idx_q <= idx_q + 1'b1;
				end
				ppu_pkg::ST_TK_LOAD: begin
					if (expire) begin
						live_q[idx_q] <= 1'b0;
						idx_q         <= idx_q + 1'b1;
					end
				end
				ppu_pkg::ST_TK_WB: idx_q <= idx_q + 1'b1;
				ppu_pkg::ST_DR_OUT: begin
					if (out_free) idx_q <= idx_q + 1'b1;
				end
				default: idx_q <= idx_q;
			endcase
		end
	end

	// output valid: set on a load, cleared once the transaction is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rsp_valid_q <= 1'b0;
		else if (state_q == ppu_pkg::ST_DR_OUT && out_free) rsp_valid_q <= 1'b1;
		else if (!rsp_stall) rsp_valid_q <= 1'b0;
	end

	// tick datapath
	always_ff @(posedge clk) begin
		if (accept) step_q <= req.time_step;
		case (state_q)
			ppu_pkg::ST_TK_LOAD: begin
				ent_q     <= load_ent;
				prod_q    <= {32'd0, mag_x} * {32'd0, step_q};
			end
			ppu_pkg::ST_TK_MX: begin
				ent_q.place_x <= ent_q.place_x + delta;
				prod_q        <= {32'd0, mag_y} * {32'd0, step_q};
			end
			ppu_pkg::ST_TK_MY: ent_q.place_y <= ent_q.place_y + delta;
			ppu_pkg::ST_TK_DIV: begin
				if (div_done) interp_q <= div_quo;
			end
			default: interp_q <= interp_q;
		endcase
	end

	// draw output register
	always_ff @(posedge clk) begin
		if (state_q == ppu_pkg::ST_DR_OUT && out_free) begin
			rsp_q.slot        <= 6'(idx_q);
			rsp_q.out_x       <= rd_q.place_x;
			rsp_q.out_y       <= rd_q.place_y;
			rsp_q.out_size    <= rd_q.side;
			rsp_q.out_colour  <= rd_q.now_colour;
			rsp_q.out_texture <= rd_q.handles[15:0];
			rsp_q.out_shader  <= rd_q.handles[31:16];
			rsp_q.last        <= last_live;
		end
	end

	ppu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (ent_q.age),
		.den    (ent_q.lifespan),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
